>>> sv/amf_pkg.sv
// Package for the address mirror fold block.
// Holds the default bus width and the number of bit steps per pipeline stage.
// No dependencies.
`default_nettype none

package amf_pkg;

  // Default width of the bus address.
  localparam int ADDR_BITS_DEF = 28;

  // Bit positions handled in one pipeline stage.
  localparam int STEPS_PER_STAGE = 4;

endpackage

`default_nettype wire

>>> sv/amf_stage.sv
// One pipeline stage of the address mirror fold: a short chain of bit steps.
// The stage is followed by its own register.
// Depends on amf_pkg.
`default_nettype none

module amf_stage #(
  parameter int ADDR_BITS = amf_pkg::ADDR_BITS_DEF,
  parameter int FIRST_BIT = amf_pkg::ADDR_BITS_DEF - 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 ce,
  input  wire logic                 in_valid,
  input  wire logic [ADDR_BITS-1:0] in_addr,
  input  wire logic [ADDR_BITS:0]   in_size,
  input  wire logic [ADDR_BITS-1:0] in_base,
  output logic                      valid_r,
  output logic [ADDR_BITS-1:0]      addr_r,
  output logic [ADDR_BITS:0]        size_r,
  output logic [ADDR_BITS-1:0]      base_r
);

  localparam int STEPS = amf_pkg::STEPS_PER_STAGE;

  logic [ADDR_BITS-1:0] addr_c [STEPS+1];
  logic [ADDR_BITS:0]   size_c [STEPS+1];
  logic [ADDR_BITS-1:0] base_c [STEPS+1];

  assign addr_c[0] = in_addr;
  assign size_c[0] = in_size;
  assign base_c[0] = in_base;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int BIT = FIRST_BIT - k;
    if (BIT >= 0) begin : g_live
      localparam logic [ADDR_BITS-1:0] BA = ADDR_BITS'(1) << BIT;
      localparam logic [ADDR_BITS:0]   BS = (ADDR_BITS + 1)'(1) << BIT;
      logic take;
      logic shrink;
      // A set address bit is cleared only while the address still reaches the size.
      assign take   = ({1'b0, addr_c[k]} >= size_c[k]) && addr_c[k][BIT];
      assign shrink = take && (size_c[k] > BS);
      assign addr_c[k+1] = take ? (addr_c[k] & ~BA) : addr_c[k];
      assign size_c[k+1] = shrink ? (size_c[k] - BS) : size_c[k];
      assign base_c[k+1] = shrink ? (base_c[k] | BA) : base_c[k];
    end else begin : g_idle
      assign addr_c[k+1] = addr_c[k];
      assign size_c[k+1] = size_c[k];
      assign base_c[k+1] = base_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      addr_r <= addr_c[STEPS];
      size_r <= size_c[STEPS];
      base_r <= base_c[STEPS];
    end
  end

endmodule

`default_nettype wire

>>> sv/address_mirror_fold.sv
// Top level of the address mirror fold: a pipeline of bit-step stages and
// a final add into the output register. Depends on amf_pkg and amf_stage.
//
//   Channel | Direction | Contents
//   in_     | slave     | tdata: bus_address, region_size
//   out_    | master    | tdata: folded_address
//
// One beat enters per cycle while the output is not stalled; each register stage
// holds four bit steps, and the final add feeds the output register.
// rst_n clears the valid bits of all stages and the output register.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module address_mirror_fold #(
  parameter int ADDR_BITS = amf_pkg::ADDR_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // bus_address [ADDR_BITS-1:0], region_size [2*ADDR_BITS:ADDR_BITS], zero fill
  input  wire logic [((2*ADDR_BITS+1+7)/8)*8-1:0]     in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // folded_address [ADDR_BITS-1:0], zero fill
  output logic [((ADDR_BITS+7)/8)*8-1:0]              out_tdata
);

  localparam int STEPS      = amf_pkg::STEPS_PER_STAGE;
  localparam int NUM_STAGES = (ADDR_BITS + STEPS - 1) / STEPS;
  localparam int OUT_W      = ((ADDR_BITS + 7) / 8) * 8;

  logic                 stg_valid [NUM_STAGES+1];
  logic [ADDR_BITS-1:0] stg_addr  [NUM_STAGES+1];
  logic [ADDR_BITS:0]   stg_size  [NUM_STAGES+1];
  logic [ADDR_BITS-1:0] stg_base  [NUM_STAGES+1];

  logic                 ce;
  logic                 out_valid_r;
  logic [ADDR_BITS-1:0] out_data_r;
  logic [ADDR_BITS:0]   sum;

  // The pipeline moves whenever the output register is empty or being drained.
  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  assign stg_valid[0] = in_tvalid;
  assign stg_addr[0]  = in_tdata[ADDR_BITS-1:0];
  assign stg_size[0]  = in_tdata[2*ADDR_BITS:ADDR_BITS];
  assign stg_base[0]  = '0;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    amf_stage #(
      .ADDR_BITS (ADDR_BITS),
      .FIRST_BIT (ADDR_BITS - 1 - s * STEPS)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .ce       (ce),
      .in_valid (stg_valid[s]),
      .in_addr  (stg_addr[s]),
      .in_size  (stg_size[s]),
      .in_base  (stg_base[s]),
      .valid_r  (stg_valid[s+1]),
      .addr_r   (stg_addr[s+1]),
      .size_r   (stg_size[s+1]),
      .base_r   (stg_base[s+1])
    );
  end

  // The remaining size only matters inside the stages.
  assign sum = {1'b0, stg_base[NUM_STAGES]} + {1'b0, stg_addr[NUM_STAGES]}
             + ((ADDR_BITS + 1)'(0) & stg_size[NUM_STAGES]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= stg_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data_r <= sum[ADDR_BITS-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

endmodule

`default_nettype wire

>>> tb/address_mirror_fold_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for address_mirror_fold: it folds random and corner-case
// addresses into regions of many sizes and compares every output beat with its own fold.
// Depends on amf_pkg and the address_mirror_fold RTL.

module address_mirror_fold_tb;

  localparam int ADDR_BITS = amf_pkg::ADDR_BITS_DEF;
  localparam int SIZE_BITS = ADDR_BITS + 1;
  localparam int IN_W      = ((2*ADDR_BITS+1+7)/8)*8;
  localparam int OUT_W     = ((ADDR_BITS+7)/8)*8;
  localparam int HOLD_LEN  = 300;
  localparam int DRAIN_CYCLES = 24;

  localparam logic [ADDR_BITS-1:0] ADDR_MAX  = '1;
  localparam logic [SIZE_BITS-1:0] SIZE_FULL = SIZE_BITS'(1) << ADDR_BITS;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  wire              in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  wire              out_tvalid;
  logic             out_tready = 1'b0;
  wire  [OUT_W-1:0] out_tdata;

  logic [ADDR_BITS-1:0] pending_folds[$];
  int  fail_count = 0;
  int  folds_sent = 0;
  int  folds_checked = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  stall_left = 0;

  address_mirror_fold dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Bit-serial fold from the top bus bit down; base collects the weights that the
  // region size can still give up.
  function automatic logic [ADDR_BITS-1:0] mirror_fold(input logic [ADDR_BITS-1:0] addr_in,
                                                       input logic [SIZE_BITS-1:0] size_in);
    logic [SIZE_BITS-1:0] addr;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] base;
    logic [SIZE_BITS-1:0] weight;
    logic [SIZE_BITS-1:0] sum;
    if (size_in == '0) return '0;
    addr = {1'b0, addr_in};
    size = size_in;
    base = '0;
    for (int b = ADDR_BITS - 1; b >= 0; b--) begin
      weight = SIZE_BITS'(1) << b;
      if (addr >= size && (addr & weight) != '0) begin
        addr = addr - weight;
        if (size > weight) begin
          size = size - weight;
          base = base + weight;
        end
      end
    end
    sum = base + addr;
    return sum[ADDR_BITS-1:0];
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_fold_request(input logic [ADDR_BITS-1:0] addr,
                                   input logic [SIZE_BITS-1:0] size);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-ADDR_BITS-SIZE_BITS){1'b0}}, size, addr};
    do @(posedge clk); while (!in_tready);
    pending_folds.push_back(mirror_fold(addr, size));
    folds_sent++;
  endtask

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_served + 1;
      out_tready  <= 1'b0;
      stall_left  <= HOLD_LEN - 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_folds.size() == 0) begin
        $error("output beat with no fold pending: folded_address 0x%07h",
               out_tdata[ADDR_BITS-1:0]);
        fail_count++;
      end else begin
        logic [ADDR_BITS-1:0] want;
        want = pending_folds.pop_front();
        if (out_tdata[ADDR_BITS-1:0] !== want) begin
          $error("folded_address: expected 0x%07h, got 0x%07h",
                 want, out_tdata[ADDR_BITS-1:0]);
          fail_count++;
        end
        folds_checked++;
      end
    end
  end

  // Sizes that show up in practice: powers of two, odd multiples of a power of
  // two, arbitrary values, and now and then zero or the whole bus.
  function automatic logic [SIZE_BITS-1:0] pick_size();
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, ADDR_BITS - 1);
    if (r < 4)  return '0;
    if (r < 7)  return SIZE_FULL;
    if (r < 30) return SIZE_BITS'(1) << k;
    if (r < 50) return SIZE_BITS'((2 * $urandom_range(1, 7) + 1)) << $urandom_range(0, 24);
    if (r < 75) return SIZE_BITS'($urandom_range(1, 1 << (k + 1)));
    return SIZE_BITS'($urandom_range(1, 1 << ADDR_BITS));
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_addr(input logic [SIZE_BITS-1:0] size);
    if ($urandom_range(0, 99) < 65 || size == '0 || size == SIZE_FULL)
      return ADDR_BITS'($urandom());
    // Near the region: below it, at its edge, or a few mirrors above.
    return ADDR_BITS'($urandom_range(0, 3) * size + $urandom_range(0, size - 1));
  endfunction

  task automatic test_directed_edges();
    send_fold_request(ADDR_MAX, '0);
    send_fold_request('0, '0);
    send_fold_request('0, SIZE_BITS'(1));
    send_fold_request(ADDR_MAX, SIZE_BITS'(1));
    send_fold_request(ADDR_MAX, SIZE_FULL);
    send_fold_request(ADDR_BITS'('h123_4567), SIZE_BITS'('h200_0000));
    send_fold_request(ADDR_BITS'('h10_0000), SIZE_BITS'('h10_0000));
    send_fold_request(ADDR_MAX, SIZE_BITS'(ADDR_MAX));
    send_fold_request(ADDR_BITS'('h0AB_CDEF), SIZE_BITS'('h30_0000));
    send_fold_request(ADDR_MAX, SIZE_BITS'('h18_0000));
    send_fold_request(ADDR_BITS'('h800_0000), SIZE_BITS'('h800_0000));
    send_fold_request(ADDR_BITS'('h555_5555), SIZE_BITS'('hAAA_AAAA));
    send_fold_request(ADDR_BITS'('hAAA_AAAA), SIZE_BITS'('h555_5555));
    send_fold_request(ADDR_BITS'('h7FF_FFFF), SIZE_BITS'('h800_0001));
    send_fold_request(ADDR_BITS'('h0FF_FFFF), SIZE_BITS'('h60_0000));
  endtask

  task automatic test_random_mix(input int count);
    logic [SIZE_BITS-1:0] size;
    for (int i = 0; i < count; i++) begin
      size = pick_size();
      send_fold_request(pick_addr(size), size);
    end
  endtask

  task automatic test_back_to_back(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_mix(count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the
  // pipeline fills and in_tready must drop.
  task automatic test_backpressure(input int count);
    tx_idle_on = 1'b0;
    hold_requests++;
    test_random_mix(count);
    tx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_back_to_back(200);
    test_backpressure(80);
    test_random_mix(1400);
    in_tvalid <= 1'b0;
    while (pending_folds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Folded %0d addresses (%0d beats checked) over zero, odd, power-of-two",
             folds_sent, folds_checked);
    $display("and full-bus region sizes, with random gaps, long stalls and back-to-back beats.");
    if (fail_count == 0) begin
      $display("address_mirror_fold_tb OK");
    end else begin
      $display("address_mirror_fold_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("address_mirror_fold_tb NOT OK");
    $finish;
  end

endmodule
